/* rtl/nfd_pkg.sv */
package nfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = 32;

  // spacing, sample difference, product, numerator and denominator widths
  localparam int HW   = COORD_BITS + 1;
  localparam int DW   = SAMPLE_BITS + 1;
  localparam int MW   = (HW > DW) ? HW : DW;
  localparam int PW   = 2 * MW;
  localparam int NUMW = HW + DW + 1;
  localparam int DENW = 2 * HW + 1;

  // dividend, remainder and step counter widths
  localparam int DVW0 = (NUMW + FRAC_BITS > DENW) ? NUMW + FRAC_BITS : DENW;
  localparam int DVW  = ((DVW0 > OUT_BITS) ? DVW0 : OUT_BITS) + 1;
  localparam int RW   = ((DVW - OUT_BITS > DENW) ? DVW - OUT_BITS : DENW) + 1;
  localparam int CW   = $clog2(OUT_BITS);

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FLAG   = 2'd1;
  localparam logic [1:0] STATUS_SINGLE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DIV,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RND,
    DV_CHK,
    DV_ITER,
    DV_FIN
  } div_state_t;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_ONE,
    JOB_MID
  } job_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

/* rtl/nfd_mul.sv */
module nfd_mul (
  input  logic                           clk,
  input  logic signed [nfd_pkg::MW-1:0]  a,
  input  logic signed [nfd_pkg::MW-1:0]  b,
  output logic signed [nfd_pkg::PW-1:0]  prod
);
  import nfd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PW'(a) * PW'(b);
  end

endmodule

/* rtl/nfd_div.sv */
module nfd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [nfd_pkg::NUMW-1:0]  num,
  input  logic signed [nfd_pkg::DENW-1:0]  den,
  output logic [nfd_pkg::OUT_BITS-1:0]     quot,
  output nfd_pkg::div_stat_t               stat
);
  import nfd_pkg::*;

  div_state_t          state, state_next;
  logic                neg;
  logic [NUMW-1:0]     nmag;
  logic [DENW-1:0]     dmag;
  logic [DVW-1:0]      dvd;
  logic [RW-1:0]       rem;
  logic [OUT_BITS-1:0] low;
  logic [CW-1:0]       cnt;
  logic                sat;
  logic [RW-1:0]       trial;
  logic [RW-1:0]       cmp_a;
  logic                ge;
  logic [OUT_BITS-1:0] limit;
  logic [OUT_BITS-1:0] mag;
  logic                over;

  // shared compare: overflow check, then one quotient bit per step
  always_comb begin
    trial = {rem[RW-2:0], low[OUT_BITS-1]};
    cmp_a = (state == DV_CHK) ? RW'(dvd >> OUT_BITS) : trial;
    ge    = cmp_a >= RW'(dmag);
  end

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (start) state_next = DV_RND;
      DV_RND:  state_next = DV_CHK;
      DV_CHK:  state_next = ge ? DV_FIN : DV_ITER;
      DV_ITER: if (cnt == CW'(OUT_BITS - 1)) state_next = DV_FIN;
      DV_FIN:  state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    limit = neg ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
    over  = sat || (low > limit);
    mag   = over ? limit : low;
    quot  = neg ? (~mag + 1'b1) : mag;
    stat.done = (state == DV_FIN);
    stat.sat  = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          neg  <= num[NUMW-1] ^ den[DENW-1];
          nmag <= num[NUMW-1] ? $unsigned(-num) : $unsigned(num);
          dmag <= den[DENW-1] ? $unsigned(-den) : $unsigned(den);
        end
      end
      // scale and add half the divisor for round to nearest
      DV_RND: dvd <= (DVW'(nmag) << FRAC_BITS) + DVW'(dmag >> 1);
      DV_CHK: begin
        sat <= ge;
        rem <= cmp_a;
        low <= dvd[OUT_BITS-1:0];
        cnt <= '0;
      end
      DV_ITER: begin
        rem <= ge ? (trial - RW'(dmag)) : trial;
        low <= {low[OUT_BITS-2:0], ge};
        cnt <= cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/nonuniform_first_derivative.sv */
// latency: an interior derivative passes S_PREP, S_MUL0-S_MUL3, the divider and S_EMIT;
//   a one-sided derivative skips the multiply states; a row's final point adds its backward
//   derivative after that (or emits the forward value again for a two-point row)
// throughput: one transaction at a time, bounded by the 32-step divider loop
// reset: synchronous, active high; clears the sequencer and output valid and
//   starts a new row
module nonuniform_first_derivative (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [nfd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [nfd_pkg::COORD_BITS-1:0]  coord,
  input  logic                                 last_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [nfd_pkg::OUT_BITS-1:0]  derivative,
  output logic                                 last_out,
  output logic [1:0]                           status
);
  import nfd_pkg::*;

  ctl_state_t                 state, state_next;
  logic signed [SAMPLE_BITS-1:0] older_sample, newer_sample;
  logic signed [COORD_BITS-1:0]  older_coord, newer_coord;
  logic [1:0]                 points_seen;
  logic signed [DW-1:0]       dd0, dd1;
  logic signed [HW-1:0]       h0, h1;
  job_t                       job;
  logic                       back_pending;
  logic signed [NUMW-1:0]     acc;
  logic [OUT_BITS-1:0]        res_value;
  logic [1:0]                 res_status;
  logic                       res_last;
  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [PW-1:0]       prod;
  logic                       div_start;
  logic signed [NUMW-1:0]     div_num;
  logic signed [DENW-1:0]     div_den;
  logic [OUT_BITS-1:0]        quot;
  div_stat_t                  dstat;
  logic                       accept;
  logic                       load_out;
  logic                       h0_zero, h1_zero;

  nfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  nfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .stat  (dstat)
  );

  assign h0_zero = (h0 == '0);
  assign h1_zero = (h1 == '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = (points_seen == 2'd0 && !last_in) ? S_IDLE : S_PREP;
      end
      S_PREP: begin
        if (job == JOB_SINGLE) begin
          state_next = S_EMIT;
        end else if (job == JOB_ONE) begin
          state_next = h1_zero ? S_EMIT : S_DIV;
        end else begin
          state_next = (h0_zero || h1_zero) ? S_EMIT : S_MUL0;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_DIV;
      S_DIV: begin
        if (dstat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          if (!back_pending) state_next = S_IDLE;
          else if (job == JOB_ONE) state_next = S_EMIT;
          else state_next = S_PREP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    accept    = in_valid && in_ready;
    load_out  = (state == S_EMIT) && (!out_valid || out_ready);
    div_start = ((state == S_PREP) && (job == JOB_ONE) && !h1_zero) || (state == S_MUL3);
    div_num   = (state == S_MUL3) ? acc : NUMW'(dd1);
    div_den   = (state == S_MUL3) ? (DENW'(prod) <<< 1) : DENW'(h1);
    mul_a     = (state == S_MUL1) ? MW'(h1) : MW'(h0);
    case (state)
      S_MUL0:  mul_b = MW'(dd1);
      S_MUL1:  mul_b = MW'(dd0);
      default: mul_b = MW'(h1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      points_seen  <= 2'd0;
      back_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        back_pending <= last_in && (points_seen != 2'd0);
        if (last_in) points_seen <= 2'd0;
        else points_seen <= (points_seen == 2'd0) ? 2'd1 : 2'd2;
      end else if (load_out) begin
        back_pending <= 1'b0;
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dd1      <= DW'(sample) - DW'(newer_sample);
      dd0      <= DW'(newer_sample) - DW'(older_sample);
      h1       <= HW'(coord) - HW'(newer_coord);
      h0       <= HW'(newer_coord) - HW'(older_coord);
      res_last <= (points_seen == 2'd0);
      if (points_seen == 2'd0) job <= JOB_SINGLE;
      else if (points_seen == 2'd1) job <= JOB_ONE;
      else job <= JOB_MID;
      if (!last_in) begin
        older_sample <= newer_sample;
        older_coord  <= newer_coord;
        newer_sample <= sample;
        newer_coord  <= coord;
      end
    end
    if (state == S_PREP) begin
      res_value  <= '0;
      res_status <= (job == JOB_SINGLE) ? STATUS_SINGLE : STATUS_FLAG;
    end
    if (state == S_MUL1) acc <= NUMW'(prod);
    if (state == S_MUL2) acc <= acc + NUMW'(prod);
    if (state == S_DIV && dstat.done) begin
      res_value  <= quot;
      res_status <= dstat.sat ? STATUS_FLAG : STATUS_OK;
    end
    if (load_out) begin
      derivative <= res_value;
      last_out   <= res_last;
      status     <= res_status;
      // backward difference at the row end
      if (back_pending) begin
        res_last <= 1'b1;
        job      <= JOB_ONE;
      end
    end
  end

endmodule

/* rtl/nfd_chk.sv */
module nfd_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [nfd_pkg::SAMPLE_BITS-1:0] sample,
  input logic signed [nfd_pkg::COORD_BITS-1:0]  coord,
  input logic                                   last_in,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [nfd_pkg::OUT_BITS-1:0]    derivative,
  input logic                                   last_out,
  input logic [1:0]                             status
);
  import nfd_pkg::*;

  localparam logic [OUT_BITS-1:0] MAX_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] MAX_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(derivative) && $stable(last_out)
      && $stable(status))
    else $error("result changed while stalled");

  // one-sample row gives zero and closes the row
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_SINGLE |-> last_out && derivative == '0)
    else $error("bad one-sample result");

  // flagged result is zero or a saturation limit
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FLAG |->
      derivative == '0 || derivative == MAX_POS || derivative == MAX_NEG)
    else $error("flagged result not zero or saturated");

  // a row end always produces work, so input stalls next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_in |=> !in_ready)
    else $error("ready after row end transaction");

endmodule

bind nonuniform_first_derivative nfd_chk u_nfd_chk (.*);
